// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL of the allocation range table.
// Needs nothing else; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/art_pkg.sv -----
// Package of the allocation range table: request and status codes, field widths.
// No dependencies.
`timescale 1ns / 1ps

package art_pkg;

    localparam int REQ_W    = 3;
    localparam int STATUS_W = 2;
    localparam int ADDR_W   = 64;
    localparam int LEN_W    = 32;
    localparam int ID_W     = 8;

    // request codes
    localparam logic [REQ_W-1:0] REQ_ADD    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_FIND   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_FREE   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    // one record as held in the table memory
    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [ADDR_W-1:0] base;
    } t_record;

endpackage

// ----- rtl/allocation_range_table.sv -----
// Allocation range table: records of base/length/freed, searched newest first.
// Depends on art_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage
//   Request channel (i_s_*): tuser carries the request code (0 add, 1 find,
//   2 free, 3 range lookup, 4 clear), tdata carries address and length.
//   Response channel (o_m_*): exactly one response per request, in order;
//   tuser carries the status (0 ok, 1 not found, 2 full), tdata carries the
//   record id, base and length (zeros when nothing matched).
//   Add, clear and unknown codes finish without a scan; find, free and
//   lookup scan the records held, one record per cycle from the table
//   memory (registered read), newest first, and stop at the first hit.
//   One request is worked at a time; the next is accepted once the
//   previous response sits in the output register, even if it is
//   stalled. A stalled receiver holds the response; a finished request
//   waits in its last step until the output register frees.
//   Reset (synchronous, active low) empties the table and drops any
//   response; record contents in memory are not cleared, only the count
//   and the freed marks.
module allocation_range_table #(
    parameter int DEPTH = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [95:0]  i_s_tdata,   // [63:0] address, [95:64] length
    input  logic [2:0]   i_s_tuser,   // [2:0] req_type
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [103:0] o_m_tdata,   // [7:0] entry_id, [71:8] entry_base,
                                      // [103:72] entry_length
    output logic [1:0]   o_m_tuser    // [1:0] status
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // captured request
    logic [art_pkg::REQ_W-1:0]  r_req;
    logic [art_pkg::ADDR_W-1:0] r_addr;
    logic [art_pkg::LEN_W-1:0]  r_len;

    // table state
    logic [CW-1:0]    r_count, n_count;
    logic [DEPTH-1:0] r_freed, n_freed;

    // scan control: r_ptr is the next entry to read, r_pend_* the one in flight
    logic [IW-1:0] r_ptr, n_ptr;
    logic          r_more, n_more;
    logic          r_pend_v, n_pend_v;
    logic [IW-1:0] r_pend_idx, n_pend_idx;

    // finished result, waiting for the output register
    logic [art_pkg::STATUS_W-1:0] r_res_status, n_res_status;
    logic [art_pkg::ID_W-1:0]     r_res_id, n_res_id;
    logic [art_pkg::ADDR_W-1:0]   r_res_base, n_res_base;
    logic [art_pkg::LEN_W-1:0]    r_res_len, n_res_len;

    // output register
    logic                         r_out_v, n_out_v;
    logic [art_pkg::STATUS_W-1:0] r_out_status;
    logic [art_pkg::ID_W-1:0]     r_out_id;
    logic [art_pkg::ADDR_W-1:0]   r_out_base;
    logic [art_pkg::LEN_W-1:0]    r_out_len;
    logic                         w_out_load;

    // table memory
    art_pkg::t_record r_mem [DEPTH];
    art_pkg::t_record r_rd_data;
    art_pkg::t_record w_wdata;
    logic             w_we;
    logic [IW-1:0]    w_waddr;

    logic                     w_accept;
    logic                     w_full;
    logic [art_pkg::ADDR_W:0] w_diff;
    logic                     w_exact;
    logic                     w_range;
    logic                     w_hit;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_full     = (r_count == CW'(DEPTH));

    // compare of the record in flight against the probe
    assign w_diff  = {1'b0, r_addr} - {1'b0, r_rd_data.base};
    assign w_exact = (r_rd_data.base == r_addr);
    assign w_range = !w_diff[art_pkg::ADDR_W] && (w_diff[art_pkg::ADDR_W-1:art_pkg::LEN_W] == '0)
                     && (w_diff[art_pkg::LEN_W-1:0] < r_rd_data.len);
    assign w_hit   = r_pend_v && !r_freed[r_pend_idx]
                     && ((r_req == art_pkg::REQ_LOOKUP) ? w_range : w_exact);

    assign w_wdata = '{len: r_len, base: r_addr};
    assign w_waddr = IW'(r_count);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= r_mem[r_ptr];
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_freed      = r_freed;
        n_ptr        = r_ptr;
        n_more       = r_more;
        n_pend_v     = 1'b0;
        n_pend_idx   = r_pend_idx;
        n_res_status = r_res_status;
        n_res_id     = r_res_id;
        n_res_base   = r_res_base;
        n_res_len    = r_res_len;
        w_we         = 1'b0;
        w_out_load   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res_status = art_pkg::ST_NOT_FOUND;
                n_res_id     = '0;
                n_res_base   = '0;
                n_res_len    = '0;
                n_state      = S_DONE;
                case (r_req)
                    art_pkg::REQ_ADD: begin
                        if (w_full) begin
                            n_res_status = art_pkg::ST_FULL;
                        end else begin
                            w_we               = 1'b1;
                            n_freed[w_waddr]   = 1'b0;
                            n_count            = r_count + 1'b1;
                            n_res_status       = art_pkg::ST_OK;
                            n_res_id           = art_pkg::ID_W'(r_count);
                            n_res_base         = r_addr;
                            n_res_len          = r_len;
                        end
                    end
                    art_pkg::REQ_FIND, art_pkg::REQ_FREE, art_pkg::REQ_LOOKUP: begin
                        if (r_count != '0) begin
                            n_ptr   = IW'(r_count - 1'b1);
                            n_more  = 1'b1;
                            n_state = S_SCAN;
                        end
                    end
                    art_pkg::REQ_CLEAR: begin
                        n_freed      = '0;
                        n_count      = '0;
                        n_res_status = art_pkg::ST_OK;
                    end
                    default: begin
                    end
                endcase
            end
            S_SCAN: begin
                if (w_hit) begin
                    n_res_status = art_pkg::ST_OK;
                    n_res_id     = art_pkg::ID_W'(r_pend_idx);
                    n_res_base   = r_rd_data.base;
                    n_res_len    = r_rd_data.len;
                    if (r_req == art_pkg::REQ_FREE) begin
                        n_freed[r_pend_idx] = 1'b1;
                    end
                    n_state = S_DONE;
                end else if (!r_pend_v && !r_more) begin
                    // nothing left in flight: miss, result already zeroed
                    n_state = S_DONE;
                end else begin
                    // issue the read at r_ptr (memory reads r_ptr every cycle)
                    n_pend_v   = r_more;
                    n_pend_idx = r_ptr;
                    if (r_ptr == '0) begin
                        n_more = 1'b0;
                    end else begin
                        n_ptr = r_ptr - 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_v || i_m_tready) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_v = w_out_load || (r_out_v && !i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_freed  <= '0;
            r_more   <= 1'b0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_freed  <= n_freed;
            r_more   <= n_more;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req  <= i_s_tuser;
            r_addr <= i_s_tdata[63:0];
            r_len  <= i_s_tdata[95:64];
        end
        r_ptr        <= n_ptr;
        r_pend_idx   <= n_pend_idx;
        r_res_status <= n_res_status;
        r_res_id     <= n_res_id;
        r_res_base   <= n_res_base;
        r_res_len    <= n_res_len;
        if (w_out_load) begin
            r_out_status <= r_res_status;
            r_out_id     <= r_res_id;
            r_out_base   <= r_res_base;
            r_out_len    <= r_res_len;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {r_out_len, r_out_base, r_out_id};

    `ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH))
    `ASSERT_IMPL(a_pend_in_table, i_clk, i_rst_n, r_pend_v, CW'(r_pend_idx) < r_count)
    `ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, w_accept, r_state == S_EXEC)
    `ASSERT_IMPL(a_full_only_on_add, i_clk, i_rst_n,
                 (r_state == S_DONE) && (r_res_status == art_pkg::ST_FULL),
                 r_req == art_pkg::REQ_ADD)
    `ASSERT_NEXT(a_load_sets_valid, i_clk, i_rst_n, w_out_load, o_m_tvalid)

endmodule
